FILE: rtl/peaking_biquad_filter_defines.svh
// Assertion macros shared by the filter RTL.
`ifndef PEAKING_BIQUAD_FILTER_DEFINES_SVH
`define PEAKING_BIQUAD_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PBQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pbq_pkg.sv
package pbq_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes; the five product terms use the same numbering.
  localparam logic [CFG_IDX_W-1:0] REG_NUM0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORM = 3'd5;

  typedef struct packed {
    logic load;   // take new multiplier and multiplicand
    logic clear;  // preset the accumulator
    logic step;   // retire one radix-4 digit
  } pbq_mac_ctrl_t;

endpackage

FILE: rtl/pbq_if.sv
interface pbq_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface pbq_out_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: rtl/pbq_mac.sv
module pbq_mac #(
  parameter int unsigned P_W   = 66,
  parameter int unsigned MUL_W = 26
) (
  input  logic                   clk_i,
  input  pbq_pkg::pbq_mac_ctrl_t ctrl_i,
  input  logic [MUL_W-1:0]       mul_i,
  input  logic [P_W-1:0]         mcand_i,
  input  logic [P_W-1:0]         init_i,
  output logic [P_W-1:0]         acc_o
);
  import pbq_pkg::*;

  logic [MUL_W-1:0] mul_q;
  logic             prev_q;
  logic [P_W-1:0]   mcand_q;
  logic [P_W-1:0]   acc_q;

  logic [2:0]       win;
  logic [P_W-1:0]   pp;
  logic             neg;
  logic [P_W-1:0]   sum;

  // Radix-4 Booth digit from the two low multiplier bits and the last one shifted out.
  assign win = {mul_q[1:0], prev_q};

  always_comb begin
    pp  = '0;
    neg = 1'b0;
    if (win inside {3'b001, 3'b010}) begin
      pp = mcand_q;
    end else if (win == 3'b011) begin
      pp = {mcand_q[P_W-2:0], 1'b0};
    end else if (win == 3'b100) begin
      pp  = {mcand_q[P_W-2:0], 1'b0};
      neg = 1'b1;
    end else if (win inside {3'b101, 3'b110}) begin
      pp  = mcand_q;
      neg = 1'b1;
    end
  end

  assign sum = acc_q + (neg ? ~pp : pp) + P_W'(neg);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mul_q   <= mul_i;
      prev_q  <= 1'b0;
      mcand_q <= mcand_i;
    end else if (ctrl_i.step) begin
      mul_q   <= {{2{mul_q[MUL_W-1]}}, mul_q[MUL_W-1:2]};
      prev_q  <= mul_q[1];
      mcand_q <= {mcand_q[P_W-3:0], 2'b00};
    end
    if (ctrl_i.clear) begin
      acc_q <= init_i;
    end else if (ctrl_i.step) begin
      acc_q <= sum;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/peaking_biquad_filter.sv
// One sample is in work at a time, so a new input word is taken only after the last
// result has moved to the output register. The single radix-4 Booth multiply-accumulate
// unit, two multiplier bits per cycle, serves all five product terms and the norm multiply.
// Reset (async, active low) clears the delay line and loads pass-through coefficients.
`include "peaking_biquad_filter_defines.svh"

module peaking_biquad_filter #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pbq_in_if.sink                         in_if,
  pbq_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [pbq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]          cfg_data_i
);
  import pbq_pkg::*;

  localparam int unsigned SW         = SAMPLE_WIDTH;
  localparam int unsigned CW         = COEF_WIDTH;
  localparam int unsigned ACC_W      = SW + CW + 2;
  localparam int unsigned P_W        = ACC_W + CW;
  localparam int unsigned TOTAL_FRAC = 2 * CW - 9;
  localparam int unsigned YF_W       = P_W - TOTAL_FRAC;
  localparam int unsigned MUL_RAW    = (SW > CW + 1) ? SW : CW + 1;
  localparam int unsigned MUL_W      = MUL_RAW + (MUL_RAW % 2);
  localparam int unsigned STEPS_S    = (SW + 1) / 2;
  localparam int unsigned STEPS_N    = (CW + 2) / 2;
  localparam int unsigned STEPS_MAX  = (STEPS_S > STEPS_N) ? STEPS_S : STEPS_N;
  localparam int unsigned CNT_W      = $clog2(STEPS_MAX);

  localparam logic [CW-1:0]  NUM0_RST = {{(CW-1){1'b0}}, 1'b1} << (CW - 8);
  localparam logic [CW-1:0]  NORM_RST = {1'b1, {(CW-1){1'b0}}};
  localparam logic [P_W-1:0] HALF     = {{(P_W-1){1'b0}}, 1'b1} << (TOTAL_FRAC - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_NLOAD = 3'd3;
  localparam logic [2:0] ST_NRUN  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CFG_IDX_W-1:0] term_q, term_d;

  logic signed [CW-1:0] coef_num0_q, coef_num1_q, coef_num2_q, coef_fb1_q, coef_fb2_q;
  logic [CW-1:0]        coef_norm_q;
  logic signed [SW-1:0] x1_q, x2_q, y1_q, y2_q;
  logic signed [SW-1:0] x_q;
  logic                 out_valid_q;
  logic [SW-1:0]        out_data_q;

  pbq_mac_ctrl_t        mac_ctrl;
  logic [MUL_W-1:0]     mac_mul;
  logic [P_W-1:0]       mac_mcand;
  logic [P_W-1:0]       mac_init;
  logic [P_W-1:0]       acc;

  logic signed [SW-1:0] term_smp;
  logic signed [CW-1:0] term_coef;
  logic [YF_W-1:0]      y_full;
  logic                 ovf;
  logic [SW-1:0]        y_sat;
  logic                 in_acc;
  logic                 fin;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign fin         = (state_q == ST_DONE) && (!out_valid_q || out_if.ready);

  assign out_if.valid      = out_valid_q;
  assign out_if.sample_out = out_data_q;

  always_comb begin
    term_smp  = '0;
    term_coef = '0;
    case (term_q)
      REG_NUM0: begin term_smp = x_q;  term_coef = coef_num0_q; end
      REG_NUM1: begin term_smp = x1_q; term_coef = coef_num1_q; end
      REG_NUM2: begin term_smp = x2_q; term_coef = coef_num2_q; end
      REG_FB1:  begin term_smp = y1_q; term_coef = coef_fb1_q;  end
      REG_FB2:  begin term_smp = y2_q; term_coef = coef_fb2_q;  end
      default:  begin term_smp = '0;   term_coef = '0;          end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    term_d    = term_q;
    mac_ctrl  = '0;
    mac_mul   = MUL_W'(term_smp);
    mac_mcand = P_W'(term_coef);
    mac_init  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          term_d  = REG_NUM0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mac_ctrl.load  = 1'b1;
        mac_ctrl.clear = (term_q == REG_NUM0);
        cnt_d          = '0;
        state_d        = ST_RUN;
      end
      ST_RUN: begin
        mac_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS_S - 1)) begin
          if (term_q == REG_FB2) begin
            state_d = ST_NLOAD;
          end else begin
            term_d  = term_q + 1'b1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_NLOAD: begin
        // Multiply the finished sum by the norm; preset half an output LSB for rounding.
        mac_ctrl.load  = 1'b1;
        mac_ctrl.clear = 1'b1;
        mac_mul        = MUL_W'(coef_norm_q);
        mac_mcand      = acc;
        mac_init       = HALF;
        cnt_d          = '0;
        state_d        = ST_NRUN;
      end
      ST_NRUN: begin
        mac_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS_N - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (fin) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  pbq_mac #(
    .P_W   (P_W),
    .MUL_W (MUL_W)
  ) u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .mul_i   (mac_mul),
    .mcand_i (mac_mcand),
    .init_i  (mac_init),
    .acc_o   (acc)
  );

  // Drop the fraction, then clamp when the integer part does not fit the sample.
  assign y_full = acc[P_W-1:TOTAL_FRAC];
  assign ovf    = ~(&y_full[YF_W-1:SW-1]) & (|y_full[YF_W-1:SW-1]);
  assign y_sat  = !ovf ? y_full[SW-1:0] :
                  y_full[YF_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      term_q      <= REG_NUM0;
      out_valid_q <= 1'b0;
      coef_num0_q <= NUM0_RST;
      coef_num1_q <= '0;
      coef_num2_q <= '0;
      coef_fb1_q  <= '0;
      coef_fb2_q  <= '0;
      coef_norm_q <= NORM_RST;
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      term_q  <= term_d;
      if (fin) begin
        out_valid_q <= 1'b1;
        x2_q        <= x1_q;
        x1_q        <= x_q;
        y2_q        <= y1_q;
        y1_q        <= y_sat;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NUM0: coef_num0_q <= cfg_data_i;
          REG_NUM1: coef_num1_q <= cfg_data_i;
          REG_NUM2: coef_num2_q <= cfg_data_i;
          REG_FB1:  coef_fb1_q  <= cfg_data_i;
          REG_FB2:  coef_fb2_q  <= cfg_data_i;
          REG_NORM: coef_norm_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_if.sample_in;
    end
    if (fin) begin
      out_data_q <= y_sat;
    end
  end

  `PBQ_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_acc, state_q == ST_LOAD, "accepted word did not start the sum")
  `PBQ_ASSERT_NEXT(a_delay_hold, clk_i, rst_ni, !fin, $stable(x1_q) && $stable(y1_q), "delay line moved without a finished sample")
  `PBQ_ASSERT_IMPL(a_valid_from_fin, clk_i, rst_ni, $rose(out_valid_q), $past(fin), "output word raised without a finished sample")
  `PBQ_ASSERT_IMPL(a_run_count, clk_i, rst_ni, state_q == ST_RUN, cnt_q <= CNT_W'(STEPS_S - 1), "product step count overran")

endmodule

FILE: dv/peaking_biquad_filter_check.sv
module peaking_biquad_filter_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [15:0]                   sample_in_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [15:0]                   sample_out_i,
  input  logic                          cfg_we_i,
  input  logic [pbq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [23:0]                   cfg_data_i,
  output int                            mismatches_o,
  output int                            in_flight_o
);
  import pbq_pkg::*;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [23:0] coef_t;

  // Products carry 2^-31, the normalised sum 2^-54; output LSB is 2^-15.
  localparam int                FRAC_BITS  = 39;
  localparam logic signed [95:0] ROUND_HALF = 96'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [95:0] SAT_HI     = 96'sd32767;
  localparam logic signed [95:0] SAT_LO     = -96'sd32768;

  coef_t       num0, num1, num2, fb1, fb2;
  logic [23:0] norm;
  sample_t     x1, x2, y1, y2;
  sample_t     pending_samples[$];
  sample_t     expected;
  int          mismatch_count;

  // Next output sample; advances the delay line.
  function automatic sample_t filter_next(input sample_t x);
    logic signed [47:0] acc;
    logic signed [24:0] norm_s;
    logic signed [95:0] scaled;
    sample_t            y;
    acc    = num0 * x + num1 * x1 + num2 * x2 + fb1 * y1 + fb2 * y2;
    norm_s = {1'b0, norm};
    scaled = (acc * norm_s + ROUND_HALF) >>> FRAC_BITS;
    if (scaled > SAT_HI) begin
      y = 16'sh7FFF;
    end else if (scaled < SAT_LO) begin
      y = 16'sh8000;
    end else begin
      y = scaled[15:0];
    end
    // feedback takes the clamped value
    x2 = x1;
    x1 = x;
    y2 = y1;
    y1 = y;
    return y;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num0 = 24'sh010000;
      num1 = '0;
      num2 = '0;
      fb1  = '0;
      fb2  = '0;
      norm = 24'h800000;
      x1   = '0;
      x2   = '0;
      y1   = '0;
      y2   = '0;
      pending_samples.delete();
      mismatch_count = 0;
      mismatches_o <= 0;
      in_flight_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NUM0: num0 = cfg_data_i;
          REG_NUM1: num1 = cfg_data_i;
          REG_NUM2: num2 = cfg_data_i;
          REG_FB1:  fb1  = cfg_data_i;
          REG_FB2:  fb2  = cfg_data_i;
          REG_NORM: norm = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pending_samples.push_back(filter_next(sample_in_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_samples.size() == 0) begin
          $display("%0t: sample_out expected none, got %0d", $time, $signed(sample_out_i));
          mismatch_count++;
        end else begin
          expected = pending_samples.pop_front();
          if (expected !== sample_out_i) begin
            $display("%0t: sample_out expected %0d, got %0d", $time, expected,
                     $signed(sample_out_i));
            mismatch_count++;
          end
        end
      end
      mismatches_o <= mismatch_count;
      in_flight_o  <= pending_samples.size();
    end
  end

endmodule

FILE: dv/peaking_biquad_filter_test.sv
module peaking_biquad_filter_test;
  import pbq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  localparam int STALL_LEN   = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int RAND_PHASES = 12;

  localparam logic [23:0] C_MIN  = 24'h800000;
  localparam logic [23:0] C_MAX  = 24'h7FFFFF;
  localparam logic [23:0] C_ONE  = 24'h010000;
  localparam logic [23:0] N_ONE  = 24'h800000;
  localparam logic [23:0] N_MAX  = 24'hFFFFFF;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [23:0]          cfg_data;

  int mismatches;
  int in_flight;
  int quiet_cycles = 0;
  int hold_requests = 0;
  bit gaps_on = 1'b1;

  pbq_in_if  #(.SAMPLE_WIDTH(16)) in_if ();
  pbq_out_if #(.SAMPLE_WIDTH(16)) out_if ();

  peaking_biquad_filter #(
    .SAMPLE_WIDTH(16),
    .COEF_WIDTH  (24)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  peaking_biquad_filter_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .sample_in_i (in_if.sample_in),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .sample_out_i(out_if.sample_out),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .in_flight_o (in_flight)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[peaking_biquad_filter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: random back-pressure, plus a long hold when asked.
  initial begin
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = STALL_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < 14) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [15:0] s);
    while (gaps_on && $urandom_range(0, 99) < 14) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Drop valid and hold until every word in flight has come out.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_coefs(input logic [23:0] n0, input logic [23:0] n1,
                           input logic [23:0] n2, input logic [23:0] f1,
                           input logic [23:0] f2, input logic [23:0] nm);
    write_reg(REG_NUM0, n0);
    write_reg(REG_NUM1, n1);
    write_reg(REG_NUM2, n2);
    write_reg(REG_FB1,  f1);
    write_reg(REG_FB2,  f2);
    write_reg(REG_NORM, nm);
  endtask

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end else if (r < 30) begin
      return 16'($urandom_range(0, 511)) - 16'd256;
    end
    return 16'($urandom);
  endfunction

  // 0: any 24-bit value, 1: within +/-2.0, 2: corner values
  function automatic logic [23:0] pick_coef(input int mode);
    if (mode == 1) begin
      return 24'($urandom_range(0, 262144)) - 24'd131072;
    end else if (mode == 2) begin
      case ($urandom_range(0, 4))
        0: return C_MIN;
        1: return C_MAX;
        2: return 24'h000000;
        3: return C_ONE;
        default: return 24'hFFFFFF;
      endcase
    end
    return 24'($urandom);
  endfunction

  function automatic logic [23:0] pick_norm(input int mode);
    if (mode == 1) begin
      return 24'($urandom_range(1 << 21, (1 << 24) - 1));
    end else if (mode == 2) begin
      case ($urandom_range(0, 3))
        0: return 24'h000000;
        1: return N_MAX;
        2: return N_ONE;
        default: return 24'h000001;
      endcase
    end
    return 24'($urandom);
  endfunction

  initial begin
    int mode;
    int count;
    in_if.valid     <= 1'b0;
    in_if.sample_in <= '0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_data        <= '0;
    rst_ni          <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients pass the input straight through.
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    wait_drained();

    // Largest gain: saturate both ways. Writes to spare indexes must be ignored.
    set_coefs(C_MAX, 24'h0, 24'h0, 24'h0, 24'h0, N_MAX);
    write_reg(REG_SPARE6, 24'h123456);
    write_reg(REG_SPARE7, 24'hFFFFFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h0064);
    send_sample(16'h0000);
    wait_drained();

    // All signed weights at their minimum, normalisation zero.
    set_coefs(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 24'h000000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h3039);
    send_sample(16'hFFFF);
    wait_drained();

    // Delay taps and feedback at opposite extremes, smallest non-zero normalisation.
    set_coefs(24'h0, C_MAX, C_MIN, C_MIN, C_MAX, 24'h000001);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'h0000);
    send_sample(16'h0000);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode = ph % 3;
      set_coefs(pick_coef(mode), pick_coef(mode), pick_coef(mode),
                pick_coef(mode), pick_coef(mode), pick_norm(mode));
      gaps_on = (ph != 3);
      count = $urandom_range(140, 175);
      for (int i = 0; i < count; i++) begin
        if (ph == 5 && i == 30) hold_requests++;
        send_sample(pick_sample());
      end
      wait_drained();
    end
    gaps_on = 1'b1;

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && in_flight == 0) begin
      $display("[peaking_biquad_filter] OK");
    end else begin
      $display("[peaking_biquad_filter] ERROR");
    end
    $finish;
  end

endmodule
